// ----- rtl/sskc_pkg.sv -----
// shared types, constants and the half-step coil table for the stepper speed and key controller
// no dependencies; imported by every module under rtl
package sskc_pkg;

  // converter sample width on the ports
  localparam int unsigned ADC_W = 10;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [1:0] CFG_POWER_LIM = 2'd1;
  localparam logic [1:0] CFG_DIR_LIM   = 2'd2;
  localparam logic [1:0] CFG_FLOOR     = 2'd3;

  // reset values of the registers
  localparam logic [7:0] DEBOUNCE_RST  = 8'd200;
  localparam logic [9:0] POWER_LIM_RST = 10'd512;
  localparam logic [9:0] DIR_LIM_RST   = 10'd900;
  localparam logic [3:0] FLOOR_RST     = 4'd9;

  // x/5 as (x*205)>>10, exact for x below 1024
  localparam int unsigned DIV5_MUL   = 205;
  localparam int unsigned DIV5_SHIFT = 10;

  localparam logic [6:0] SPEED_SAT = 7'd127;

  // item kinds carried in tuser
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    KEY_NONE  = 2'd0,
    KEY_POWER = 2'd1,
    KEY_DIR   = 2'd2
  } key_class_t;

  typedef struct packed {
    logic [7:0] debounce_limit;
    logic [9:0] power_key_limit;
    logic [9:0] direction_key_limit;
    logic [3:0] speed_floor;
  } cfg_t;

  // motor control state handed from the sample unit to the step sequencer
  typedef struct packed {
    logic       power_on;
    logic       direction_up;
    logic [6:0] speed;
  } motor_ctrl_t;

  // sample unit state as seen after the current item
  typedef struct packed {
    logic       power_on;
    logic       direction_up;
    logic [6:0] speed;
    key_class_t key_class;
  } sample_stat_t;

  function automatic logic [3:0] coil_pattern(input logic [2:0] idx);
    logic [3:0] pat;
    unique case (idx)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h3;
      3'd2: pat = 4'h2;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'hC;
      3'd6: pat = 4'h8;
      3'd7: pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/sskc_step_seq.sv -----
// half-step coil sequencer: divider counter, step index and coil register
// depends on sskc_pkg
module sskc_step_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tick_fire,
  input  sskc_pkg::motor_ctrl_t ctrl,
  output logic [3:0]           coil_after
);
  import sskc_pkg::*;

  logic [6:0] div_r, div_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [3:0] coil_r, coil_nxt;

  always_comb begin
    div_nxt  = div_r;
    idx_nxt  = idx_r;
    coil_nxt = coil_r;
    if (!ctrl.power_on) begin
      div_nxt  = '0;
      idx_nxt  = '0;
      coil_nxt = '0;
    end else if (div_r >= ctrl.speed) begin
      div_nxt  = '0;
      coil_nxt = coil_pattern(idx_r);
      idx_nxt  = ctrl.direction_up ? idx_r + 3'd1 : idx_r - 3'd1;
    end else begin
      div_nxt = div_r + 7'd1;
    end
  end

  assign coil_after = tick_fire ? coil_nxt : coil_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r  <= '0;
      idx_r  <= '0;
      coil_r <= '0;
    end else if (tick_fire) begin
      div_r  <= div_nxt;
      idx_r  <= idx_nxt;
      coil_r <= coil_nxt;
    end
  end

endmodule

// ----- rtl/sskc_sample_proc.sv -----
// sample unit: speed filter and scaling, key classification, debounce, power and direction
// depends on sskc_pkg
module sskc_sample_proc #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   sample_fire,
  input  logic [sskc_pkg::ADC_W-1:0] pot_sample,
  input  logic [sskc_pkg::ADC_W-1:0] key_sample,
  input  sskc_pkg::cfg_t         cfg,
  output sskc_pkg::motor_ctrl_t  ctrl,
  output sskc_pkg::sample_stat_t stat_after
);
  import sskc_pkg::*;

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned ACC_W  = SB + 5;
  localparam int unsigned PROD_W = SB + 6;

  logic [SB-1:0]       filt_r, filt_nxt, samp;
  logic                primed_r;
  logic [SB+ADC_W-1:0] pot_ext;
  logic [ACC_W-1:0]    acc;
  logic [SB-3:0]       quarter;
  logic [PROD_W-1:0]   prod;
  logic [8:0]          speed_sum;
  logic [6:0]          speed_r, speed_nxt;
  logic                power_r, power_nxt;
  logic                dir_r, dir_nxt;
  key_class_t          key_r, cls;
  logic [7:0]          cnt_r, cnt_nxt, cnt_inc;

  // filter: first sample primes, then (15*f + s) / 16
  assign pot_ext = {{SB{1'b0}}, pot_sample};
  assign samp    = pot_ext[SB-1:0];
  assign acc     = (ACC_W'(filt_r) << 4) - ACC_W'(filt_r) + ACC_W'(samp);
  assign filt_nxt = primed_r ? acc[SB+3:4] : samp;

  // level/20 as (level/4)/5, reciprocal multiply
  assign quarter   = filt_nxt[SB-1:2];
  assign prod      = PROD_W'(quarter) * PROD_W'(DIV5_MUL);
  assign speed_sum = 9'(prod[PROD_W-1:DIV5_SHIFT]) + 9'(cfg.speed_floor);
  assign speed_nxt = (speed_sum > 9'(SPEED_SAT)) ? SPEED_SAT : speed_sum[6:0];

  // key ladder, power key tested first
  always_comb begin
    priority if (key_sample < cfg.power_key_limit) cls = KEY_POWER;
    else if (key_sample < cfg.direction_key_limit)  cls = KEY_DIR;
    else                                            cls = KEY_NONE;
  end

  assign cnt_inc = cnt_r + 8'd1;

  always_comb begin
    cnt_nxt   = cnt_r;
    power_nxt = power_r;
    dir_nxt   = dir_r;
    if (cls != key_r) begin
      cnt_nxt = '0;
    end else if (cnt_r != cfg.debounce_limit) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc == cfg.debounce_limit) begin
        if (cls == KEY_POWER) begin
          power_nxt = !power_r;
        end else if (cls == KEY_DIR && power_r) begin
          dir_nxt = !dir_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r   <= '0;
      primed_r <= 1'b0;
      speed_r  <= '0;
      power_r  <= 1'b0;
      dir_r    <= 1'b0;
      key_r    <= KEY_NONE;
      cnt_r    <= '0;
    end else if (sample_fire) begin
      filt_r   <= filt_nxt;
      primed_r <= 1'b1;
      speed_r  <= speed_nxt;
      power_r  <= power_nxt;
      dir_r    <= dir_nxt;
      key_r    <= cls;
      cnt_r    <= cnt_nxt;
    end
  end

  assign ctrl.power_on     = power_r;
  assign ctrl.direction_up = dir_r;
  assign ctrl.speed        = speed_r;

  assign stat_after.power_on     = sample_fire ? power_nxt : power_r;
  assign stat_after.direction_up = sample_fire ? dir_nxt   : dir_r;
  assign stat_after.speed        = sample_fire ? speed_nxt : speed_r;
  assign stat_after.key_class    = sample_fire ? cls       : key_r;

endmodule

// ----- rtl/stepper_speed_key_controller_top.sv -----
// top level of the stepper speed and key controller: stream ports, config registers, pipeline
// depends on sskc_pkg, sskc_step_seq and sskc_sample_proc
//
// pipeline: each input transfer passes the input register, then the result register, which drives out_tvalid
// throughput: one item per cycle while the result stream is not stalled; each item gives exactly one result
// the input register is freed whenever the output register is empty or being taken
// reset: synchronous active-low rst_n clears all control state and loads register defaults
// no input transfer is taken while rst_n is low
module stepper_speed_key_controller_top #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [9:0] pot_sample, [19:10] key_sample, [23:20] zero
  input  logic [0:0]  in_tuser,   // [0] opcode (0 tick, 1 sample pair)
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] coil_bits, [4] running, [5] reverse,
                                  // [12:6] tick_period, [14:13] key_class, [15] zero
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [9:0]  cfg_wdata
);
  import sskc_pkg::*;

  cfg_t         cfg_r;
  logic         s1_valid_r;
  logic         s1_op_r;
  logic [ADC_W-1:0] s1_pot_r, s1_key_r;
  logic         out_valid_r;
  logic [15:0]  out_data_r, out_data_nxt;
  logic         fire;
  motor_ctrl_t  ctrl;
  sample_stat_t stat;
  logic [3:0]   coil;

  // input stage advances whenever the result register can take a new value
  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!s1_valid_r || fire);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit      <= DEBOUNCE_RST;
      cfg_r.power_key_limit     <= POWER_LIM_RST;
      cfg_r.direction_key_limit <= DIR_LIM_RST;
      cfg_r.speed_floor         <= FLOOR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_DEBOUNCE:  cfg_r.debounce_limit      <= cfg_wdata[7:0];
        CFG_POWER_LIM: cfg_r.power_key_limit     <= cfg_wdata;
        CFG_DIR_LIM:   cfg_r.direction_key_limit <= cfg_wdata;
        CFG_FLOOR:     cfg_r.speed_floor         <= cfg_wdata[3:0];
        default:       ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r  <= in_tuser[0];
      s1_pot_r <= in_tdata[9:0];
      s1_key_r <= in_tdata[19:10];
    end
  end

  // state update happens as the item leaves the input register
  sskc_step_seq u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_fire  (fire && (s1_op_r == OP_TICK)),
    .ctrl       (ctrl),
    .coil_after (coil)
  );

  sskc_sample_proc #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sample (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample_fire (fire && (s1_op_r == OP_SAMPLE)),
    .pot_sample  (s1_pot_r),
    .key_sample  (s1_key_r),
    .cfg         (cfg_r),
    .ctrl        (ctrl),
    .stat_after  (stat)
  );

  // result word: state as it stands after the item
  assign out_data_nxt = {1'b0, stat.key_class, stat.speed, stat.direction_up,
                         stat.power_on, coil};

  // result register, holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/sskc_checker.sv -----
// port-level checker for the stepper speed and key controller, bound to the top level
// depends on sskc_pkg
module sskc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  import sskc_pkg::*;

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a result being taken always frees room for a new input
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |-> in_tready)
    else $error("input stalled while result drains");

  // key class and coil drive stay within their legal codes, and the spare top bit stays zero
  a_result_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[14:13] != 2'd3) && ($countones(out_tdata[3:0]) <= 2)
                   && !out_tdata[15])
    else $error("illegal key class or coil pattern");

endmodule

bind stepper_speed_key_controller_top sskc_checker u_sskc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
